// File: src/imu_tilt_fusion_assert.svh
// assertion macros for the tilt fusion block
// used by the port checker, no other dependencies
`ifndef IMU_TILT_FUSION_ASSERT_SVH
`define IMU_TILT_FUSION_ASSERT_SVH

// same-cycle implication, off during reset
`define ITF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("imu_tilt_fusion check failed");

// next-cycle implication, off during reset
`define ITF_ASSERT_NXTD(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("imu_tilt_fusion check failed");

// next-cycle implication, always on
`define ITF_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("imu_tilt_fusion check failed");

`endif

// File: src/itf_pkg.sv
// shared types and constants of the tilt fusion block
// no dependencies
package itf_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] tilt_x;
        logic signed [15:0] tilt_y;
        logic        [15:0] accel_magnitude;
    } t_out;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 18;
    localparam int DIV_BITS_PER_CYCLE = 4;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_NUM_W-1:0] dividend;
        logic signed [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                        done;
        logic signed [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

    localparam int QUEUE_DEPTH = 2;
    localparam int DEADBAND_W = 15;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 15'd6;

    localparam logic signed [31:0] GRAVITY_RESET = 32'sd8192;
    localparam logic signed [17:0] MAG_DIV = 18'sd6724;
    localparam logic signed [32:0] RATE_MUL = 33'sd25;
    localparam logic signed [17:0] RATE_DIV = 18'sd142;
    localparam logic signed [32:0] TILT_MUL = 33'sd100;
    localparam logic signed [17:0] TILT_DIV = 18'sd143;
    localparam logic signed [32:0] SQRT_SCALE = 33'sd181;
    localparam logic [15:0] ATAN_BASE_NEG = 16'h4b66;
    localparam logic [15:0] ATAN_BASE_POS = 16'h1922;
    localparam logic signed [32:0] ATAN_K1 = 33'sh0648;
    localparam logic signed [32:0] ATAN_K2 = 33'sh1f6a;
    localparam logic [14:0] SQRT_TOP_BIT = 15'h4000;

    localparam logic [9:0] WEIGHT_NEAR = 10'd300;
    localparam logic [9:0] WEIGHT_MID = 10'd400;
    localparam logic [9:0] WEIGHT_FAR = 10'd600;
    localparam logic [9:0] WEIGHT_EDGE = 10'd800;

endpackage

// File: src/itf_front.sv
// input stage: takes a sample beat and zeroes gyro rates inside the deadband
// depends on itf_pkg
module itf_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  itf_pkg::t_in                        i_data,
    input  logic [itf_pkg::DEADBAND_W-1:0]      i_deadband,
    output logic                                o_job_valid,
    output itf_pkg::t_in                        o_job,
    input  logic                                i_job_ready
);

    logic         r_valid;
    itf_pkg::t_in r_job;
    itf_pkg::t_in n_job;

    function automatic logic signed [15:0] gate(input logic signed [15:0] g,
                                                input logic [itf_pkg::DEADBAND_W-1:0] db);
        logic [16:0] mag;
        mag = g[15] ? 17'(-17'(g)) : 17'(g);
        return (mag > {2'b00, db}) ? g : 16'sd0;
    endfunction

    always_comb begin
        n_job = i_data;
        n_job.gyro_x = gate(i_data.gyro_x, i_deadband);
        n_job.gyro_y = gate(i_data.gyro_y, i_deadband);
        n_job.gyro_z = gate(i_data.gyro_z, i_deadband);
    end

    assign o_ready = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
                r_job <= n_job;
            end else if (i_job_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: src/itf_queue.sv
// short queue between the input stage and the compute sequencer
// depends on itf_pkg
module itf_queue #(
    parameter int DEPTH = itf_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  itf_pkg::t_in i_push,
    output logic         o_pop_valid,
    output itf_pkg::t_in o_pop,
    input  logic         i_pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    itf_pkg::t_in   r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop = r_mem[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_mem[r_wr] <= i_push;
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: src/itf_div.sv
// shared signed divider, truncating, several quotient bits per cycle
// depends on itf_pkg; a zero divisor gives a zero quotient
module itf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itf_pkg::t_div_req i_req,
    output itf_pkg::t_div_rsp o_rsp
);

    localparam int NW = itf_pkg::DIV_NUM_W;
    localparam int DW = itf_pkg::DIV_DEN_W;
    localparam int STEPS = itf_pkg::DIV_BITS_PER_CYCLE;
    localparam int ITER = NW / STEPS;
    localparam int CW = $clog2(ITER + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic          r_zero;
    logic [NW-1:0] r_q;

    logic [DW:0]   n_rem;
    logic [NW-1:0] n_quo;
    logic [NW-1:0] num_mag;
    logic [DW-1:0] den_mag;

    always_comb begin
        num_mag = i_req.dividend[NW-1] ? NW'(-i_req.dividend) : NW'(i_req.dividend);
        den_mag = i_req.divisor[DW-1] ? DW'(-i_req.divisor) : DW'(i_req.divisor);
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < STEPS; k++) begin
            n_rem = {n_rem[DW-1:0], n_quo[NW-1]};
            n_quo = {n_quo[NW-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem = n_rem - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = signed'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(ITER);
                r_rem <= '0;
                r_quo <= num_mag;
                r_den <= den_mag;
                r_neg <= i_req.dividend[NW-1] ^ i_req.divisor[DW-1];
                r_zero <= (i_req.divisor == '0);
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q <= r_zero ? '0 : (r_neg ? -n_quo : n_quo);
                end
            end
        end
    end

endmodule

// File: src/itf_back.sv
// compute sequencer: filters, magnitude, gravity rotation and pull, tilt angles
// depends on itf_pkg; uses itf_div through a request/response pair
module itf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  itf_pkg::t_in      i_job,
    output logic              o_job_ready,
    output logic              o_valid,
    output itf_pkg::t_out     o_data,
    input  logic              i_ready,
    output itf_pkg::t_div_req o_div_req,
    input  itf_pkg::t_div_rsp i_div_rsp
);

    typedef enum logic [4:0] {
        S_IDLE, S_LP, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_MAG, S_RATE_MUL, S_RATE_ACC,
        S_ROT, S_BAND, S_PULL_MUL, S_PULL_ACC, S_YY, S_ZZ, S_AT0, S_AT1, S_AT2,
        S_AT3, S_AT4, S_TX_DIV, S_TX, S_AE, S_TY_DIV, S_TY, S_DONE, S_DIV_WAIT
    } t_state;

    t_state r_state;
    t_state r_ret;
    t_state r_aret;

    logic signed [15:0] r_acc  [3];
    logic signed [15:0] r_gyr  [3];
    logic signed [13:0] r_rate [3];
    logic signed [15:0] r_lp   [3];
    logic signed [31:0] r_grav [3];
    logic [15:0]        r_mag;
    logic [15:0]        r_sq;
    logic [15:0]        r_root;
    logic [15:0]        r_rem;
    logic [14:0]        r_bit;
    logic [1:0]         r_axis;
    logic [2:0]         r_step;
    logic [9:0]         r_w;
    logic signed [15:0] r_yy;
    logic signed [15:0] r_zz;
    logic signed [15:0] r_hi;
    logic signed [15:0] r_lo;
    logic [15:0]        r_base;
    logic signed [15:0] r_c;
    logic signed [19:0] r_t;
    logic signed [15:0] r_r;
    logic signed [15:0] r_tx;
    logic signed [15:0] r_ty;
    logic               r_o_valid;
    itf_pkg::t_out      r_o_data;
    logic               r_div_start;
    logic signed [47:0] r_div_num;
    logic signed [17:0] r_div_den;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] p;
    logic signed [15:0] q16;
    logic signed [15:0] lp_next [3];
    logic signed [20:0] lpw;
    logic signed [20:0] lps;
    logic [1:0]         rot_dst;
    logic [1:0]         rot_src;
    logic [1:0]         rot_rt;
    logic               rot_add;
    logic signed [31:0] rot_delta;
    logic signed [31:0] rot_new;
    logic [15:0]        sq_trial;
    logic [15:0]        sq_root;
    logic [15:0]        sq_rem;
    logic [14:0]        sq_bit;
    logic [15:0]        sq_final;
    logic [15:0]        sq_sum;
    logic [19:0]        mag_sum;
    logic [9:0]         band_w;
    logic signed [15:0] at_mag;
    logic signed [15:0] at_f;
    logic signed [15:0] at_d16;
    logic signed [17:0] at_sum;
    logic signed [17:0] at_den;
    logic [15:0]        at_base;
    logic signed [47:0] at_num;
    logic [15:0]        at_b;
    logic signed [15:0] ae16;
    logic signed [15:0] ae;
    logic signed [15:0] gx_lo;

    function automatic logic [9:0] band_weight(input logic [15:0] m);
        if (m inside {[98:102]}) begin
            return itf_pkg::WEIGHT_NEAR;
        end else if (m inside {[95:97], [103:105]}) begin
            return itf_pkg::WEIGHT_MID;
        end else if (m inside {[90:94], [106:110]}) begin
            return itf_pkg::WEIGHT_FAR;
        end else if (m inside {[85:89], [111:115]}) begin
            return itf_pkg::WEIGHT_EDGE;
        end
        return 10'd0;
    endfunction

    assign q16 = signed'(i_div_rsp.quotient[15:0]);

    // rotation order: y about pitch, x about roll, z about yaw
    always_comb begin
        rot_dst = 2'd0;
        rot_src = 2'd0;
        rot_rt = 2'd0;
        rot_add = 1'b1;
        case (r_step)
            3'd0: begin rot_dst = 2'd2; rot_src = 2'd0; rot_rt = 2'd1; rot_add = 1'b1; end
            3'd1: begin rot_dst = 2'd0; rot_src = 2'd2; rot_rt = 2'd1; rot_add = 1'b0; end
            3'd2: begin rot_dst = 2'd1; rot_src = 2'd2; rot_rt = 2'd0; rot_add = 1'b1; end
            3'd3: begin rot_dst = 2'd2; rot_src = 2'd1; rot_rt = 2'd0; rot_add = 1'b0; end
            3'd4: begin rot_dst = 2'd0; rot_src = 2'd1; rot_rt = 2'd2; rot_add = 1'b1; end
            3'd5: begin rot_dst = 2'd1; rot_src = 2'd0; rot_rt = 2'd2; rot_add = 1'b0; end
            default: begin rot_dst = 2'd0; rot_src = 2'd0; rot_rt = 2'd0; rot_add = 1'b1; end
        endcase
    end

    // one shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ_MUL: begin
                mul_a = 33'(r_acc[r_axis]);
                mul_b = 33'(r_acc[r_axis]);
            end
            S_RATE_MUL: begin
                mul_a = 33'(r_gyr[r_axis]);
                mul_b = itf_pkg::RATE_MUL;
            end
            S_ROT: begin
                mul_a = 33'(r_grav[rot_src]);
                mul_b = 33'(r_rate[rot_rt]);
            end
            S_PULL_MUL: begin
                mul_a = 33'(r_grav[r_axis]);
                mul_b = 33'(signed'({1'b0, r_w - 10'd1}));
            end
            S_YY: begin
                mul_a = 33'(r_grav[1]);
                mul_b = 33'(r_grav[1]);
            end
            S_ZZ: begin
                mul_a = 33'(r_grav[2]);
                mul_b = 33'(r_grav[2]);
            end
            S_AT1: begin
                mul_a = 33'(q16);
                mul_b = 33'(q16);
            end
            S_AT2: begin
                mul_a = 33'(r_t);
                mul_b = itf_pkg::ATAN_K1;
            end
            S_AT3: begin
                mul_a = 33'(r_t) - itf_pkg::ATAN_K2;
                mul_b = 33'(r_c);
            end
            S_TX_DIV: begin
                mul_a = 33'(r_r);
                mul_b = itf_pkg::TILT_MUL;
            end
            S_TY_DIV: begin
                mul_a = 33'(r_r);
                mul_b = -itf_pkg::TILT_MUL;
            end
            S_AE: begin
                mul_a = 33'(signed'({1'b0, r_root}));
                mul_b = itf_pkg::SQRT_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p = mul_a * mul_b;

    always_comb begin
        lpw = '0;
        lps = '0;
        for (int i = 0; i < 3; i++) begin
            lpw = 21'(r_lp[i]);
            lps = (lpw <<< 4) - lpw + 21'(r_acc[i]);
            lp_next[i] = lps[19:4];
        end
    end

    assign rot_delta = p[46:15];
    assign rot_new = rot_add ? r_grav[rot_dst] + rot_delta : r_grav[rot_dst] - rot_delta;

    // one step of the rounding square root
    always_comb begin
        sq_trial = r_root + {1'b0, r_bit};
        if (r_rem >= sq_trial) begin
            sq_rem = r_rem - sq_trial;
            sq_root = (r_root >> 1) + {1'b0, r_bit};
        end else begin
            sq_rem = r_rem;
            sq_root = r_root >> 1;
        end
        sq_bit = r_bit >> 2;
        sq_final = (sq_root < sq_rem) ? sq_root + 16'd1 : sq_root;
    end

    assign sq_sum = r_sq + q16;
    assign mag_sum = ({4'd0, r_mag} << 3) - {4'd0, r_mag} + {4'd0, r_root};
    assign band_w = band_weight(r_mag);

    always_comb begin
        at_mag = r_lo[15] ? -r_lo : r_lo;
        at_f = at_mag + 16'sd1;
        at_d16 = at_f - r_hi;
        if (r_hi[15]) begin
            at_sum = 18'(r_hi) + 18'(at_f);
            at_den = 18'(at_d16);
            at_base = itf_pkg::ATAN_BASE_NEG;
        end else begin
            at_sum = 18'(r_hi) - 18'(at_f);
            at_den = 18'(r_hi) + 18'(at_f);
            at_base = itf_pkg::ATAN_BASE_POS;
        end
        at_num = 48'(at_sum) <<< 13;
        at_b = r_base + r_t[15:0];
        if (r_lo[15]) begin
            at_b = -at_b;
        end
    end

    assign ae16 = signed'(p[15:0]);
    assign ae = ae16 >>> 2;
    assign gx_lo = r_grav[0][17:2];

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid = r_o_valid;
    assign o_data = r_o_data;
    assign o_div_req.start = r_div_start;
    assign o_div_req.dividend = r_div_num;
    assign o_div_req.divisor = r_div_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_aret <= S_IDLE;
            r_o_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_mag <= '0;
            for (int i = 0; i < 3; i++) begin
                r_lp[i] <= '0;
            end
            r_grav[0] <= '0;
            r_grav[1] <= '0;
            r_grav[2] <= itf_pkg::GRAVITY_RESET;
        end else begin
            r_div_start <= 1'b0;
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_acc[0] <= i_job.accel_x;
                        r_acc[1] <= i_job.accel_y;
                        r_acc[2] <= i_job.accel_z;
                        r_gyr[0] <= i_job.gyro_x;
                        r_gyr[1] <= i_job.gyro_y;
                        r_gyr[2] <= i_job.gyro_z;
                        r_state <= S_LP;
                    end
                end
                S_LP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_lp[i] <= lp_next[i];
                    end
                    r_sq <= '0;
                    r_axis <= 2'd0;
                    r_state <= S_SQ_MUL;
                end
                S_SQ_MUL: begin
                    r_div_start <= 1'b1;
                    r_div_num <= p[47:0];
                    r_div_den <= itf_pkg::MAG_DIV;
                    r_ret <= S_SQ_ACC;
                    r_state <= S_DIV_WAIT;
                end
                S_SQ_ACC: begin
                    if (r_axis == 2'd2) begin
                        r_rem <= sq_sum;
                        r_root <= '0;
                        r_bit <= itf_pkg::SQRT_TOP_BIT;
                        r_ret <= S_MAG;
                        r_state <= S_SQRT;
                    end else begin
                        r_sq <= sq_sum;
                        r_axis <= r_axis + 2'd1;
                        r_state <= S_SQ_MUL;
                    end
                end
                S_SQRT: begin
                    r_rem <= sq_rem;
                    r_bit <= sq_bit;
                    if (sq_bit == '0) begin
                        r_root <= sq_final;
                        r_state <= r_ret;
                    end else begin
                        r_root <= sq_root;
                    end
                end
                S_MAG: begin
                    r_mag <= mag_sum[18:3];
                    r_axis <= 2'd0;
                    r_state <= S_RATE_MUL;
                end
                S_RATE_MUL: begin
                    r_div_start <= 1'b1;
                    r_div_num <= p[47:0];
                    r_div_den <= itf_pkg::RATE_DIV;
                    r_ret <= S_RATE_ACC;
                    r_state <= S_DIV_WAIT;
                end
                S_RATE_ACC: begin
                    r_rate[r_axis] <= q16[13:0];
                    if (r_axis == 2'd2) begin
                        r_step <= 3'd0;
                        r_state <= S_ROT;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                        r_state <= S_RATE_MUL;
                    end
                end
                S_ROT: begin
                    r_grav[rot_dst] <= rot_new;
                    if (r_step == 3'd5) begin
                        r_state <= S_BAND;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_BAND: begin
                    r_w <= band_w;
                    r_axis <= 2'd0;
                    r_state <= (band_w == '0) ? S_YY : S_PULL_MUL;
                end
                S_PULL_MUL: begin
                    r_div_start <= 1'b1;
                    r_div_num <= p[47:0] + 48'(r_lp[r_axis]);
                    r_div_den <= 18'(signed'({1'b0, r_w}));
                    r_ret <= S_PULL_ACC;
                    r_state <= S_DIV_WAIT;
                end
                S_PULL_ACC: begin
                    r_grav[r_axis] <= i_div_rsp.quotient[31:0];
                    if (r_axis == 2'd2) begin
                        r_state <= S_YY;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                        r_state <= S_PULL_MUL;
                    end
                end
                S_YY: begin
                    r_yy <= p[30:15];
                    r_state <= S_ZZ;
                end
                S_ZZ: begin
                    r_zz <= p[30:15];
                    r_hi <= r_grav[2][17:2] - {15'd0, r_grav[1][17]};
                    r_lo <= r_grav[1][17:2];
                    r_aret <= S_TX_DIV;
                    r_state <= S_AT0;
                end
                S_AT0: begin
                    r_base <= at_base;
                    r_div_start <= 1'b1;
                    r_div_num <= at_num;
                    r_div_den <= at_den;
                    r_ret <= S_AT1;
                    r_state <= S_DIV_WAIT;
                end
                S_AT1: begin
                    r_c <= q16;
                    r_t <= p[32:13];
                    r_state <= S_AT2;
                end
                S_AT2: begin
                    r_t <= p[32:13];
                    r_state <= S_AT3;
                end
                S_AT3: begin
                    r_t <= p[32:13];
                    r_state <= S_AT4;
                end
                S_AT4: begin
                    r_r <= signed'(at_b);
                    r_state <= r_aret;
                end
                S_TX_DIV: begin
                    r_div_start <= 1'b1;
                    r_div_num <= p[47:0];
                    r_div_den <= itf_pkg::TILT_DIV;
                    r_ret <= S_TX;
                    r_state <= S_DIV_WAIT;
                end
                S_TX: begin
                    r_tx <= q16;
                    r_rem <= r_yy + r_zz;
                    r_root <= '0;
                    r_bit <= itf_pkg::SQRT_TOP_BIT;
                    r_ret <= S_AE;
                    r_state <= S_SQRT;
                end
                S_AE: begin
                    r_hi <= ae - {15'd0, gx_lo[15]};
                    r_lo <= gx_lo;
                    r_aret <= S_TY_DIV;
                    r_state <= S_AT0;
                end
                S_TY_DIV: begin
                    r_div_start <= 1'b1;
                    r_div_num <= p[47:0];
                    r_div_den <= itf_pkg::TILT_DIV;
                    r_ret <= S_TY;
                    r_state <= S_DIV_WAIT;
                end
                S_TY: begin
                    r_ty <= q16;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_data.tilt_x <= r_tx;
                        r_o_data.tilt_y <= r_ty;
                        r_o_data.accel_magnitude <= r_mag;
                        r_state <= S_IDLE;
                    end
                end
                S_DIV_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_state <= r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/imu_tilt_fusion.sv
// top level of the tilt fusion block: input stage, queue, sequencer, divider
// depends on itf_pkg, itf_front, itf_queue, itf_div, itf_back
//
// channel   | valid       | ready       | beat
// sample    | i_valid     | o_ready     | i_data   (accel and gyro, three axes)
// result    | o_valid     | i_ready     | o_data   (two tilts and magnitude)
// deadband  | i_cfg_valid | o_cfg_ready | i_cfg_data
//
// each sample makes up to thirteen passes through the shared divider (three
// fewer when the band weight is zero) plus two 8-step square roots
// the input stage and queue take up to three more samples while one computes
// a stalled result holds its output register, the sequencer waits behind it
// synchronous active-low reset, filter state is ready right after reset
module imu_tilt_fusion #(
    parameter int QUEUE_DEPTH = itf_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  itf_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output itf_pkg::t_out                  o_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [itf_pkg::DEADBAND_W-1:0] i_cfg_data
);

    logic [itf_pkg::DEADBAND_W-1:0] r_deadband;
    logic              f_valid;
    logic              f_ready;
    itf_pkg::t_in      f_job;
    logic              q_valid;
    logic              q_ready;
    itf_pkg::t_in      q_job;
    itf_pkg::t_div_req div_req;
    itf_pkg::t_div_rsp div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= itf_pkg::DEADBAND_RESET;
        end else if (i_cfg_valid) begin
            r_deadband <= i_cfg_data;
        end
    end

    itf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_deadband  (r_deadband),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_ready (f_ready)
    );

    itf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push       (f_job),
        .o_pop_valid  (q_valid),
        .o_pop        (q_job),
        .i_pop_ready  (q_ready)
    );

    itf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    itf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_ready (q_ready),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_ready     (i_ready),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

endmodule

// File: src/imu_tilt_fusion_chk.sv
// port checker for the tilt fusion block, bound to the top level
// depends on itf_pkg and imu_tilt_fusion_assert.svh
`include "imu_tilt_fusion_assert.svh"

module imu_tilt_fusion_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input itf_pkg::t_in                   i_data,
    input logic                           o_valid,
    input logic                           i_ready,
    input itf_pkg::t_out                  o_data,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [itf_pkg::DEADBAND_W-1:0] i_cfg_data
);

    // stalled result beat holds
    `ITF_ASSERT_NXTD(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))

    // reset leaves no result pending
    `ITF_ASSERT_NXT(a_rst_quiet, i_clk, !i_rst_n, !o_valid)

    // averaged magnitude cannot pass the largest rounded root
    `ITF_ASSERT_IMP(a_mag_bound, i_clk, i_rst_n, o_valid, o_data.accel_magnitude <= 16'd256)

    // a deadband write is accepted whenever it is offered
    `ITF_ASSERT_IMP(a_cfg_open, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind imu_tilt_fusion imu_tilt_fusion_chk u_chk (.*);
